/* src/imucf_pkg.sv */
package imucf_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ANG_W        = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_FRAC_BITS    = 8;
    localparam logic [16:0] BLEND_RESET = 17'd62915;

    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/imu_complementary_filter_unit.sv */
// Complementary tilt filter: one IMU sample in, three filtered angles (1/2^F degree) out.
// Each sample runs through one shared sequencer: for each of x and y an integer
// square root (a load step and 26 two-bit steps), a CORDIC vectoring pass
// (CORDIC_STEPS steps, capped at ATAN_ENTRIES, and a rounding step) and a gyro
// update with blend; z takes only the gyro update and blend. One shared 34x34
// multiplier forms rate times dt, the division by 128000 (a shift by 10, then a
// reciprocal of 125 applied in two multiplier passes) and both blend products.
// A zero accelerometer vector skips its CORDIC pass on that axis. The block is
// not ready while a sample is in work. The results wait in an output register,
// so the next sample can start while they are unread; the sequencer holds in its
// last state only while the previous results are still waiting.
module imu_complementary_filter_unit #(
    parameter int CORDIC_STEPS        = imucf_pkg::DEF_CORDIC_STEPS,
    parameter int ANGLE_FRACTION_BITS = imucf_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [16:0]        i_blend_weight,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_rate_x,
    input  logic signed [15:0] i_gyro_rate_y,
    input  logic signed [15:0] i_gyro_rate_z,
    input  logic [31:0]        i_timestamp_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_angle_about_x,
    output logic signed [23:0] o_angle_about_y,
    output logic signed [23:0] o_angle_about_z
);
    import imucf_pkg::*;

    localparam int STEPS   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int SHR     = 16 - ANGLE_FRACTION_BITS;
    localparam int CW      = 44;   // cordic x/y width
    localparam int DIVN_W  = 64;   // dividend for gyro divide
    // ceil(2^40 / 125) split into 17-bit halves
    localparam logic [16:0] RECIP_HI = 17'd67108;
    localparam logic [16:0] RECIP_LO = 17'd113247;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQRT  = 8'b0000_0010,
        S_CORD  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_BLEND = 8'b0010_0000,
        S_SAT   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [1:0]  r_axis;       // 0 x, 1 y, 2 z
    logic [16:0] r_alpha;
    logic [31:0] r_prev_ts;
    logic signed [23:0] r_filt [3];
    logic signed [23:0] r_out_x, r_out_y, r_out_z;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [15:0] r_dt;
    logic [33:0] r_sq_v;
    logic [4:0]  r_cnt;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [27:0]   r_cz;
    logic signed [23:0]   r_tilt;
    logic [DIVN_W-1:0] r_num;
    logic [DIVN_W-1:0] r_quo;
    logic              r_dphase;
    logic              r_neg;
    logic signed [63:0] r_acc;
    logic [1:0]         r_bph;
    logic signed [63:0] r_mterm;

    logic signed [15:0] sel_num, sel_a, sel_b, sel_g;
    always_comb begin
        if (r_axis == 2'd0) begin
            sel_num = r_ay; sel_a = r_ax; sel_b = r_az; sel_g = r_gx;
        end else if (r_axis == 2'd1) begin
            sel_num = r_ax; sel_a = r_ay; sel_b = r_az; sel_g = r_gy;
        end else begin
            sel_num = '0; sel_a = '0; sel_b = '0; sel_g = r_gz;
        end
    end

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;
    always_comb begin
        mul_a = '0; mul_b = '0;
        case (r_state)
            S_MUL: begin
                mul_a = 34'(sel_g);
                mul_b = {18'd0, r_dt};
            end
            S_DIV: begin
                mul_a = {1'b0, r_num[42:10]};
                mul_b = r_dphase ? {17'd0, RECIP_HI} : {17'd0, RECIP_LO};
            end
            S_BLEND: begin
                mul_a = (r_bph == 2'd2) ? 34'(r_acc) : 34'(r_tilt);
                mul_b = (r_bph == 2'd2) ? {17'd0, r_alpha} : 34'(18'd65536 - {1'b0, r_alpha});
            end
            default: begin
                mul_a = '0; mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic [33:0] sq_in;
    logic signed [CW-1:0] xs, ys;
    logic [21:0] atv;
    logic signed [63:0] blend_sum;
    logic signed [47:0] blend_shr;
    always_comb begin
        sq_in = 34'($signed(sel_a) * $signed(sel_a)) + 34'($signed(sel_b) * $signed(sel_b));
        xs = r_cx >>> r_cnt;
        ys = r_cy >>> r_cnt;
        atv = atan_q16(r_cnt);
        blend_sum = r_acc + r_mterm + 64'sd32768;
        blend_shr = 48'(blend_sum >>> 16);
    end

    // root of (sum << 16): restoring, 2 bits per step over 26 steps on a 52 bit value
    logic [51:0] r_rad;
    logic [51:0] rt_rem_try;
    logic [51:0] rt_rem_nx;
    logic [25:0] r_root;
    logic [51:0] r_rrem;
    always_comb begin
        rt_rem_nx  = {r_rrem[49:0], r_rad[51:50]};
        rt_rem_try = rt_rem_nx - {24'd0, r_root, 2'b01};
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alpha   <= BLEND_RESET;
            r_prev_ts <= '0;
            r_filt[0] <= '0;
            r_filt[1] <= '0;
            r_filt[2] <= '0;
            o_valid   <= 1'b0;
            r_axis    <= '0;
        end else begin
            if (i_cfg_valid)
                r_alpha <= (i_blend_weight > 17'd65536) ? 17'd65536 : i_blend_weight;
            if (o_valid && i_ready && (r_state != S_OUT))
                o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_ax <= i_accel_x; r_ay <= i_accel_y; r_az <= i_accel_z;
                        r_gx <= i_gyro_rate_x; r_gy <= i_gyro_rate_y;
                        r_gz <= i_gyro_rate_z;
                        r_dt <= ((i_timestamp_ms - r_prev_ts) > 32'd65535) ? 16'hFFFF
                                : 16'(i_timestamp_ms - r_prev_ts);
                        r_prev_ts <= i_timestamp_ms;
                        r_axis <= 2'd0;
                        r_state <= S_SQRT;
                        r_cnt <= '0;
                        r_root <= '0;
                        r_rrem <= '0;
                        r_rad  <= '0;
                        r_sq_v <= '0;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 5'd0 && r_rad == '0 && r_root == '0 && r_rrem == '0 &&
                        r_sq_v != 34'h3FFFFFFFF) begin
                        r_rad  <= {2'b00, sq_in, 16'd0};
                        r_sq_v <= 34'h3FFFFFFFF;
                    end else begin
                        r_rad <= {r_rad[49:0], 2'b00};
                        if (!rt_rem_try[51]) begin
                            r_rrem <= rt_rem_try;
                            r_root <= {r_root[24:0], 1'b1};
                        end else begin
                            r_rrem <= rt_rem_nx;
                            r_root <= {r_root[24:0], 1'b0};
                        end
                        if (r_cnt == 5'd25) begin
                            r_state <= S_CORD;
                            r_cnt   <= '0;
                            r_sq_v  <= '0;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                    if (r_cnt == 5'd25) begin
                        r_cx <= CW'(!rt_rem_try[51] ? {r_root[24:0], 1'b1}
                                                    : {r_root[24:0], 1'b0});
                        r_cy <= CW'(sel_num) <<< 8;
                        r_cz <= '0;
                    end
                end
                S_CORD: begin
                    if (r_cnt == 5'(STEPS)) begin
                        if (r_cx == '0 && r_cy == '0 && r_cz == '0)
                            r_tilt <= '0;
                        else
                            r_tilt <= 24'((r_cz + (28'sd1 <<< (SHR-1))) >>> SHR);
                        r_state <= S_MUL;
                    end else if (r_cx == '0 && r_cy == '0 && r_cz == '0 && r_cnt == '0) begin
                        r_cnt <= 5'(STEPS);
                    end else begin
                        if (r_cy >= 0) begin
                            r_cx <= r_cx + ys; r_cy <= r_cy - xs;
                            r_cz <= r_cz + $signed({6'd0, atv});
                        end else begin
                            r_cx <= r_cx - ys; r_cy <= r_cy + xs;
                            r_cz <= r_cz - $signed({6'd0, atv});
                        end
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_MUL: begin
                    r_neg  <= mul_p[67];
                    r_num  <= (DIVN_W'(mul_p[67] ? 68'(-mul_p) : mul_p) << ANGLE_FRACTION_BITS)
                              + DIVN_W'(64000);
                    r_dphase <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // low half of the reciprocal first, then fold in the high half
                    if (!r_dphase) begin
                        r_quo    <= 64'(mul_p >>> 17);
                        r_dphase <= 1'b1;
                    end else begin
                        r_quo   <= 64'((mul_p + 68'(r_quo)) >>> 23);
                        r_state <= S_BLEND;
                        r_bph   <= '0;
                    end
                end
                S_BLEND: begin
                    if (r_bph == 2'd0) begin
                        // first fold gyro angle into r_acc
                        r_acc <= 64'(r_filt[r_axis]) + (r_neg ? -$signed(r_quo) : $signed(r_quo));
                        r_bph <= 2'd1;
                    end else if (r_bph == 2'd1) begin
                        r_mterm <= 64'(mul_p);
                        r_bph   <= 2'd2;
                    end else begin
                        r_acc   <= r_mterm;
                        r_mterm <= 64'(mul_p);
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (blend_shr > 48'sd8388607)
                        r_filt[r_axis] <= 24'sd8388607;
                    else if (blend_shr < -48'sd8388608)
                        r_filt[r_axis] <= -24'sd8388608;
                    else
                        r_filt[r_axis] <= 24'(blend_shr);
                    if (r_axis == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_cnt  <= '0; r_root <= '0; r_rrem <= '0; r_rad <= '0;
                        r_sq_v <= '0;
                        if (r_axis == 2'd1) begin
                            r_tilt <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the previous transaction has left the output register
                    if (!o_valid || i_ready) begin
                        r_out_x <= r_filt[0];
                        r_out_y <= r_filt[1];
                        r_out_z <= r_filt[2];
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_angle_about_x = r_out_x;
    assign o_angle_about_y = r_out_y;
    assign o_angle_about_z = r_out_z;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    import imucf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int CORDIC_STEPS   = DEF_CORDIC_STEPS;
    localparam int FRAC_BITS      = DEF_FRAC_BITS;
    localparam int ANG_MAX        = 8388607;
    localparam int ANG_MIN        = -8388608;

    typedef struct {
        logic signed [15:0] ax, ay, az;
        logic signed [15:0] gx, gy, gz;
        logic [31:0]        ts;
    } t_imu_sample;

    typedef struct {
        logic signed [23:0] x, y, z;
    } t_tilt_angles;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [16:0]        i_blend_weight;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_accel_x, i_accel_y, i_accel_z;
    logic signed [15:0] i_gyro_rate_x, i_gyro_rate_y, i_gyro_rate_z;
    logic [31:0]        i_timestamp_ms;
    logic               o_valid;
    logic               i_ready;
    logic signed [23:0] o_angle_about_x, o_angle_about_y, o_angle_about_z;

    imu_complementary_filter_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_blend_weight (i_blend_weight),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_gyro_rate_x  (i_gyro_rate_x),
        .i_gyro_rate_y  (i_gyro_rate_y),
        .i_gyro_rate_z  (i_gyro_rate_z),
        .i_timestamp_ms (i_timestamp_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_angle_about_x(o_angle_about_x),
        .o_angle_about_y(o_angle_about_y),
        .o_angle_about_z(o_angle_about_z)
    );

    // predictor state
    logic [16:0]  model_weight;
    logic [31:0]  model_prev_ts;
    longint       model_fx, model_fy, model_fz;

    t_tilt_angles expected_angles[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           holdoff_left;
    int           mismatches;
    int           results_seen;
    int           samples_sent;
    int           idle_cycles;
    logic [31:0]  last_ts;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // atan2(num, sqrt(a^2+b^2)) in degrees, FRAC_BITS fraction bits
    function automatic longint accel_tilt(input longint num, input longint a, input longint b);
        longint unsigned sum;
        longint x, y, z, xs, ys;
        sum = longint'(a * a + b * b);
        x = longint'(int_sqrt(sum << 16));
        y = num * 256;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_q16(5'(i)));
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_q16(5'(i)));
            end
        end
        return (z + (64'sd1 <<< (16 - FRAC_BITS - 1))) >>> (16 - FRAC_BITS);
    endfunction

    function automatic longint blend_axis(input longint prev, input longint rate,
                                          input longint dt, input longint acc);
        longint alpha, p, q, g, v;
        longint unsigned mag;
        alpha = (model_weight > 17'd65536) ? 65536 : longint'(model_weight);
        p = rate * dt;
        mag = longint'(p < 0 ? -p : p) << FRAC_BITS;
        q = longint'((mag + 64000) / 128000);
        g = prev + (p < 0 ? -q : q);
        v = (alpha * g + (65536 - alpha) * acc + 32768) >>> 16;
        if (v > ANG_MAX) v = ANG_MAX;
        if (v < ANG_MIN) v = ANG_MIN;
        return v;
    endfunction

    function automatic t_tilt_angles predict_angles(input t_imu_sample s);
        t_tilt_angles r;
        logic [31:0] dt;
        longint tx, ty;
        dt = s.ts - model_prev_ts;
        if (dt > 32'd65535) dt = 32'd65535;
        tx = accel_tilt(s.ay, s.ax, s.az);
        ty = accel_tilt(s.ax, s.ay, s.az);
        model_fx = blend_axis(model_fx, s.gx, longint'(dt), tx);
        model_fy = blend_axis(model_fy, s.gy, longint'(dt), ty);
        model_fz = blend_axis(model_fz, s.gz, longint'(dt), 0);
        model_prev_ts = s.ts;
        r.x = model_fx[23:0];
        r.y = model_fy[23:0];
        r.z = model_fz[23:0];
        return r;
    endfunction

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_tilt_angles e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen <= results_seen + 1;
            if (expected_angles.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d",
                             o_angle_about_x, o_angle_about_y, o_angle_about_z);
            end else begin
                e = expected_angles.pop_front();
                if (e.x !== o_angle_about_x || e.y !== o_angle_about_y
                        || e.z !== o_angle_about_z) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 e.x, e.y, e.z, o_angle_about_x, o_angle_about_y,
                                 o_angle_about_z);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a rising edge; returns at the edge where the transaction happens
    task automatic send_sample(input t_imu_sample s);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_accel_x      <= s.ax;
        i_accel_y      <= s.ay;
        i_accel_z      <= s.az;
        i_gyro_rate_x  <= s.gx;
        i_gyro_rate_y  <= s.gy;
        i_gyro_rate_z  <= s.gz;
        i_timestamp_ms <= s.ts;
        do @(posedge i_clk); while (!o_ready);
        expected_angles.push_back(predict_angles(s));
        samples_sent++;
        last_ts = s.ts;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [16:0] w);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_blend_weight <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_weight = w;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_axis();
        case ($urandom_range(19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_imu_sample random_sample(input logic [31:0] prev);
        t_imu_sample s;
        int k;
        s.ax = pick_axis();
        s.ay = pick_axis();
        s.az = pick_axis();
        s.gx = pick_axis();
        s.gy = pick_axis();
        s.gz = pick_axis();
        if ($urandom_range(49) == 0) begin
            s.ax = 0;
            s.ay = 0;
            s.az = 0;
        end
        k = $urandom_range(99);
        if (k < 85)      s.ts = prev + $urandom_range(60);
        else if (k < 95) s.ts = prev + $urandom_range(50000, 200000);
        else             s.ts = $urandom;
        return s;
    endfunction

    function automatic t_imu_sample make_sample(input int a, input int g,
                                                input logic [31:0] ts);
        t_imu_sample s;
        s.ax = 16'(a);
        s.ay = 16'(a);
        s.az = 16'(a);
        s.gx = 16'(g);
        s.gy = 16'(g);
        s.gz = 16'(g);
        s.ts = ts;
        return s;
    endfunction

    task automatic test_directed();
        t_imu_sample s;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // first sample after reset measures dt from zero
        send_sample(make_sample(1000, 500, 32'd7));
        send_sample(make_sample(0, 0, 32'd7));              // zero vector, no time
        send_sample(make_sample(-32768, -32768, 32'd1007));
        send_sample(make_sample(32767, 32767, 32'd66542));
        send_sample(make_sample(32767, 32767, 32'd300000)); // long gap clamps
        send_sample(make_sample(-32768, 32767, 32'hFFFF_FFF0));
        send_sample(make_sample(12, -32768, 32'd5));        // counter wraps
        s = make_sample(0, 32767, 32'h0001_0004);
        s.az = 16'sh7FFF;
        send_sample(s);
        s = make_sample(0, -1, 32'h0001_0005);
        s.ay = 16'sh8000;
        send_sample(s);
        s = make_sample(-1, 1, 32'h0001_0006);
        s.ax = 16'sh0001;
        send_sample(s);
        s = make_sample(0, 0, 32'h0001_0010);
        s.ax = 16'sh7FFF;
        send_sample(s);
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(32767, 32767, last_ts + 32'd65535));
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(-32768, -32768, last_ts + 32'd65535));
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_sample(random_sample(last_ts));
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = HOLDOFF_CYCLES;
        for (int i = 0; i < 20; i++) send_sample(random_sample(last_ts));
        // hold the sender back until every result is in, then carry on
        wait_drained();
        for (int i = 0; i < 20; i++) send_sample(random_sample(last_ts));
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_blend_weight <= '0;
        i_valid        <= 1'b0;
        i_accel_x      <= '0;
        i_accel_y      <= '0;
        i_accel_z      <= '0;
        i_gyro_rate_x  <= '0;
        i_gyro_rate_y  <= '0;
        i_gyro_rate_z  <= '0;
        i_timestamp_ms <= '0;
        model_weight  = BLEND_RESET;
        model_prev_ts = '0;
        model_fx = 0;
        model_fy = 0;
        model_fz = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 0;
        mismatches     = 0;
        results_seen   = 0;
        samples_sent   = 0;
        idle_cycles    = 0;
        last_ts        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400, 0, 0);
        write_weight(17'd65536);
        test_random(100, 79, 0);
        write_weight(17'd0);
        test_random(100, 0, 79);
        write_weight(17'd131071);          // above one, used as one
        test_random(100, 35, 35);
        write_weight(17'd65537);
        test_backpressure();
        write_weight(17'd32768);
        test_random(300, 79, 0);
        write_weight(17'($urandom));
        test_random(250, 0, 79);
        write_weight(BLEND_RESET);
        test_random(260, 35, 35);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d samples, %0d results, weights 0..131071, zero vectors, gaps",
                 samples_sent, results_seen);
        $display("timestamp wrap, saturation, long output hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
src/imucf_pkg.sv
src/imu_complementary_filter_unit.sv
tb/sv/tb_top.sv
